// ----- sv/cbae_pkg.sv -----
// shared constants, types and a function of the context binary arithmetic encoder
`default_nettype none
package cbae_pkg;

    localparam int MODEL_INDEX_BITS_DEF = 16;
    localparam int WEIGHT_BITS_DEF      = 12;
    localparam int SYMBOL_BITS_DEF      = 8;

    localparam int STATE_W = 12;
    localparam int COUNT_W = 6;
    localparam int CTX_W   = 5;
    localparam int BYTE_W  = 8;

    localparam logic [STATE_W-1:0] MODEL_RESET     = 12'd2048;
    localparam logic [CTX_W-1:0]   CTX_BITS_RESET  = 5'd13;
    localparam logic [31:0]        RANGE_HIGH_INIT = 32'hFFFF_FFFF;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [BYTE_W-1:0]  t_byte;

    function automatic t_state next_state(input t_state s, input logic b);
        logic [COUNT_W:0] c1;
        logic [COUNT_W:0] c0;
        c1 = {1'b0, s[COUNT_W-1:0]} + (COUNT_W+1)'(b);
        c0 = {1'b0, s[STATE_W-1:COUNT_W]} + (COUNT_W+1)'(!b);
        if (c1[COUNT_W] || c0[COUNT_W]) begin
            c1 = c1 >> 1;
            c0 = c0 >> 1;
        end
        return {c0[COUNT_W-1:0], c1[COUNT_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// ----- sv/cbae_if.sv -----
// channel interfaces: input items, code bytes and configuration writes
`default_nettype none
interface cbae_in_if import cbae_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  action;
    t_byte symbol;
    modport source (output valid, output action, output symbol, input ready);
    modport sink   (input valid, input action, input symbol, output ready);
endinterface

interface cbae_out_if import cbae_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte code_byte;
    logic  last;
    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);
endinterface

interface cbae_cfg_if import cbae_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CTX_W-1:0] context_bits;
    modport source (output valid, output context_bits, input ready);
    modport sink   (input valid, input context_bits, output ready);
endinterface
`default_nettype wire

// ----- sv/context_binary_arith_encoder.sv -----
// top level: adaptive context-modelled binary arithmetic encoder
// An encode beat codes SYMBOL_BITS bits of the symbol MSB first; each bit passes
// through model memory read, weight multiply, range multiply, range update and
// renormalise check, the check repeating once per code byte produced, and an item
// finishes with a closing step that sends any held byte marked last. The model
// memory read and both multiplies are registered. A flush beat emits code bytes
// until the range is back at its initial value, then closes the same way. After
// reset the model memory is cleared at one entry a cycle, all 2**MODEL_INDEX_BITS
// entries, before the first item is taken; configuration writes are taken at any
// time.
`default_nettype none
module context_binary_arith_encoder import cbae_pkg::*; #(
    parameter int MODEL_INDEX_BITS = MODEL_INDEX_BITS_DEF,
    parameter int WEIGHT_BITS      = WEIGHT_BITS_DEF,
    parameter int SYMBOL_BITS      = SYMBOL_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cbae_in_if.sink     i_in,
    cbae_out_if.source  o_out,
    cbae_cfg_if.sink    i_cfg
);
    localparam int IB = MODEL_INDEX_BITS;
    localparam int KW = $clog2(SYMBOL_BITS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_LOOK, S_MUL, S_UPD, S_NORM, S_FLUSH, S_END
    } t_fsm;

    t_fsm             r_st, n_st;
    logic [IB:0]      r_clr, n_clr;
    logic [CTX_W-1:0] r_ctx;
    logic [31:0]      r_low, n_low, r_high, n_high, r_hist, n_hist, r_p2, n_p2;
    logic [KW-1:0]    r_k, n_k;
    t_byte            r_sym, n_sym;
    logic [IB-1:0]    r_idx, n_idx;
    logic             r_hold_v, n_hold_v;
    t_byte            r_hold, n_hold;
    logic             r_out_v, n_out_v, r_out_last, n_out_last;
    t_byte            r_out_b, n_out_b;

    logic [CTX_W-1:0]    eff_bits;
    logic [IB-1:0]       mask, idx;
    t_state              rdata;
    logic [WEIGHT_BITS:0] weight;
    logic                ram_we;
    logic [IB-1:0]       ram_waddr;
    t_state              ram_wdata;
    logic [3:0]          kx;
    logic                cur_bit, out_free, can_emit, top_eq, do_emit, done_flush;
    logic [31:0]         v;
    logic [31:0]         span;

    assign eff_bits = (r_ctx > CTX_W'(IB)) ? CTX_W'(IB) : r_ctx;
    always_comb begin
        for (int i = 0; i < IB; i++) begin
            mask[i] = (eff_bits > CTX_W'(i));
        end
    end
    assign idx = r_hist[IB-1:0] & mask;

    assign kx      = 4'(r_k);
    assign cur_bit = (kx < 4'd8) ? r_sym[kx[2:0]] : 1'b0;

    assign ram_we    = (r_st == S_CLEAR) || (r_st == S_LOOK);
    assign ram_waddr = (r_st == S_CLEAR) ? r_clr[IB-1:0] : r_idx;
    assign ram_wdata = (r_st == S_CLEAR) ? MODEL_RESET : next_state(rdata, cur_bit);

    cbae_ram #(.WIDTH(STATE_W), .DEPTH(2 ** IB)) u_model (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx),
        .o_rdata (rdata)
    );

    cbae_weight #(.WEIGHT_BITS(WEIGHT_BITS)) u_weight (
        .i_clk    (i_clk),
        .i_state  (rdata),
        .o_weight (weight)
    );

    assign out_free   = !r_out_v || o_out.ready;
    assign can_emit   = !r_hold_v || out_free;
    assign top_eq     = (r_low[31:24] == r_high[31:24]);
    assign done_flush = (r_low == 32'd0) && (r_high == RANGE_HIGH_INIT);
    assign v          = r_low + r_p2;
    assign span       = r_high - r_low;

    assign i_in.ready  = (r_st == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid     = r_out_v;
    assign o_out.code_byte = r_out_b;
    assign o_out.last      = r_out_last;

    always_comb begin
        n_st = r_st; n_clr = r_clr; n_low = r_low; n_high = r_high;
        n_hist = r_hist; n_p2 = r_p2; n_k = r_k; n_sym = r_sym; n_idx = r_idx;
        n_hold_v = r_hold_v; n_hold = r_hold;
        n_out_v = r_out_v && !o_out.ready; n_out_b = r_out_b; n_out_last = r_out_last;
        do_emit = 1'b0;
        unique case (r_st)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == (IB+1)'(2 ** IB - 1)) begin
                    n_st = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sym = i_in.symbol;
                    n_k   = KW'(SYMBOL_BITS - 1);
                    n_st  = i_in.action ? S_FLUSH : S_RD;
                end
            end
            S_RD: begin
                n_idx = idx;
                n_st  = S_LOOK;
            end
            S_LOOK: n_st = S_MUL;
            S_MUL: begin
                n_p2 = (span >> WEIGHT_BITS) * 32'(weight);
                n_st = S_UPD;
            end
            S_UPD: begin
                if (cur_bit) begin
                    n_low = v + 32'd1;
                end else begin
                    n_high = v;
                end
                n_hist = {r_hist[30:0], cur_bit};
                n_st   = S_NORM;
            end
            S_NORM: begin
                if (top_eq) begin
                    do_emit = can_emit;
                end else if (r_k == '0) begin
                    n_st = S_END;
                end else begin
                    n_k  = r_k - 1'b1;
                    n_st = S_RD;
                end
            end
            S_FLUSH: begin
                if (!done_flush) begin
                    do_emit = can_emit;
                end else begin
                    n_st = S_END;
                end
            end
            S_END: begin
                if (!r_hold_v) begin
                    n_st = S_IDLE;
                end else if (out_free) begin
                    n_out_v = 1'b1; n_out_b = r_hold; n_out_last = 1'b1;
                    n_hold_v = 1'b0;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
        if (do_emit) begin
            if (r_hold_v) begin
                n_out_v = 1'b1; n_out_b = r_hold; n_out_last = 1'b0;
            end
            n_hold_v = 1'b1;
            n_hold   = r_low[31:24];
            n_low    = {r_low[23:0], 8'h00};
            n_high   = {r_high[23:0], 8'hFF};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLEAR;
            r_clr    <= '0;
            r_ctx    <= CTX_BITS_RESET;
            r_low    <= 32'd0;
            r_high   <= RANGE_HIGH_INIT;
            r_hist   <= 32'd0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_clr    <= n_clr;
            if (i_cfg.valid) begin
                r_ctx <= i_cfg.context_bits;
            end
            r_low    <= n_low;
            r_high   <= n_high;
            r_hist   <= n_hist;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
        r_p2       <= n_p2;
        r_k        <= n_k;
        r_sym      <= n_sym;
        r_idx      <= n_idx;
        r_hold     <= n_hold;
        r_out_b    <= n_out_b;
        r_out_last <= n_out_last;
    end
endmodule
`default_nettype wire

// ----- sv/cbae_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none
module cbae_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/cbae_weight.sv -----
// split weight from the two counts via reciprocal table and one multiply
`default_nettype none
module cbae_weight import cbae_pkg::*; #(
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire t_state             i_state,
    output logic [WEIGHT_BITS:0]    o_weight
);
    localparam int RK = WEIGHT_BITS + 14;
    localparam int MW = RK;
    localparam int PW = MW + COUNT_W + 1;

    logic [MW-1:0]        w_recip [256];
    logic [COUNT_W:0]     c1p;
    logic [7:0]           den;
    logic [PW-1:0]        prod;

    for (genvar g = 0; g < 256; g++) begin : g_recip
        localparam longint unsigned DV = (g < 2) ? 1 : g;
        localparam longint unsigned MV =
            (g < 2) ? 0 : (((64'd1 << RK) + DV - 1) / DV);
        assign w_recip[g] = MW'(MV);
    end

    assign c1p  = {1'b0, i_state[COUNT_W-1:0]} + 7'd1;
    assign den  = 8'(i_state[COUNT_W-1:0]) + 8'(i_state[STATE_W-1:COUNT_W]) + 8'd2;
    assign prod = PW'(c1p) * PW'(w_recip[den]);

    always_ff @(posedge i_clk) begin
        o_weight <= prod[WEIGHT_BITS+14:14];
    end
endmodule
`default_nettype wire
